### rtl/fpba_pkg.sv
// ----------------------------------------------------------------------------
// fpba_pkg
// Shared types, codes and field layout of the fit policy block allocator.
// ----------------------------------------------------------------------------
package fpba_pkg;

   localparam int NUM_BLOCKS_DEF      = 16;
   localparam int SLOTS_PER_BLOCK_DEF = 8;

   localparam int SIZE_W   = 16;
   localparam int BIDX_W   = 4;
   localparam int POL_W    = 2;
   localparam int STAT_W   = 2;
   localparam int OSLOT_W  = 3;

   // request tdata layout
   localparam int REQ_IDX_LO   = 0;
   localparam int REQ_SIZE_LO  = 4;
   localparam int REQ_BUSY_BIT = 20;
   localparam int REQ_PID_LO   = 21;
   localparam int REQ_PSIZE_LO = 37;
   localparam int REQ_DATA_W   = 56;

   // response tdata layout
   localparam int RSP_BLK_LO   = 0;
   localparam int RSP_REM_LO   = 4;
   localparam int RSP_SLOT_LO  = 20;
   localparam int RSP_REC_BIT  = 23;
   localparam int RSP_DATA_W   = 24;

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_ALLOC = 1'b1;

   localparam logic [POL_W-1:0] POL_FIRST = 2'd0;
   localparam logic [POL_W-1:0] POL_BEST  = 2'd1;
   localparam logic [POL_W-1:0] POL_WORST = 2'd2;

   localparam logic [STAT_W-1:0] ST_ALLOCATED = 2'd0;
   localparam logic [STAT_W-1:0] ST_NO_FIT    = 2'd1;
   localparam logic [STAT_W-1:0] ST_LOADED    = 2'd2;
   localparam logic [STAT_W-1:0] ST_UNUSED    = 2'd3;

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_REDUCE = 3'b010,
      S_COMMIT = 3'b100
   } state_type;

   typedef struct packed {
      logic capture;
      logic reduce;
      logic commit;
   } dp_cmd_type;

   typedef struct packed {
      logic in_alloc;
   } dp_stat_type;

endpackage

### rtl/fit_policy_block_allocator.sv
// ----------------------------------------------------------------------------
// fit_policy_block_allocator
// First / best / worst fit allocator over a table of memory blocks.
// ----------------------------------------------------------------------------
//  channel  | direction | tdata / tuser
//  req_     | in        | tuser: command; tdata: block_index, load_size,
//           |           |   block_in_use, process_id, process_size
//  rsp_     | out       | tuser: status; tdata: chosen_block, remaining_size,
//           |           |   slot_index, slot_recorded
//  csr_     | in        | data: fit_policy
//
// Load: accept, then commit. Allocate: accept, one reduce step per level of the
// shared pairwise reduction, then commit. A new request is accepted only after
// the previous one commits. Response shows the cycle after commit
// and is registered.
// Reset is synchronous; all blocks come up in use with no slots held.
// A stalled response holds commit of the next request; capture and
// reduction of that request still proceed.
// ----------------------------------------------------------------------------
module fit_policy_block_allocator
   import fpba_pkg::*;
#(
   parameter int NUM_BLOCKS      = NUM_BLOCKS_DEF,
   parameter int SLOTS_PER_BLOCK = SLOTS_PER_BLOCK_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic                  req_tuser,   // [0] command
   // [3:0] block_index, [19:4] load_size, [20] block_in_use,
   // [36:21] process_id, [52:37] process_size, [55:53] zero
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [STAT_W-1:0]     rsp_tuser,   // [1:0] status
   // [3:0] chosen_block, [19:4] remaining_size, [22:20] slot_index,
   // [23] slot_recorded
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [POL_W-1:0]      csr_data     // [1:0] fit_policy
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   assign csr_ready = 1'b1;

   fpba_ctrl #(
      .NUM_BLOCKS (NUM_BLOCKS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

   fpba_datapath #(
      .NUM_BLOCKS      (NUM_BLOCKS),
      .SLOTS_PER_BLOCK (SLOTS_PER_BLOCK)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_tuser (req_tuser),
      .req_tdata (req_tdata),
      .csr_we    (csr_valid & csr_ready),
      .csr_data  (csr_data),
      .rsp_tuser (rsp_tuser),
      .rsp_tdata (rsp_tdata)
   );

endmodule

### rtl/fpba_datapath.sv
// ----------------------------------------------------------------------------
// fpba_datapath
// Block table, candidate reduction tree and response register.
// ----------------------------------------------------------------------------
module fpba_datapath
   import fpba_pkg::*;
#(
   parameter int NUM_BLOCKS      = NUM_BLOCKS_DEF,
   parameter int SLOTS_PER_BLOCK = SLOTS_PER_BLOCK_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  dp_cmd_type            cmd,
   output dp_stat_type           stat,
   input  logic                  req_tuser,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  csr_we,
   input  logic [POL_W-1:0]      csr_data,
   output logic [STAT_W-1:0]     rsp_tuser,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int IDX_W  = $clog2(NUM_BLOCKS);
   localparam int NP     = 1 << IDX_W;
   localparam int SLOT_W = (SLOTS_PER_BLOCK > 1) ? $clog2(SLOTS_PER_BLOCK) : 1;

   // block table
   logic [SIZE_W-1:0]          free_ff  [NUM_BLOCKS];
   logic [SIZE_W-1:0]          free_in  [NUM_BLOCKS];
   logic [NUM_BLOCKS-1:0]      busy_ff, busy_in;
   logic [SLOTS_PER_BLOCK-1:0] slots_ff [NUM_BLOCKS];
   logic [SLOTS_PER_BLOCK-1:0] slots_in [NUM_BLOCKS];
   logic [POL_W-1:0]           pol_ff;

   // captured request
   logic              cmd_ff;
   logic [BIDX_W-1:0] ld_idx_ff;
   logic [SIZE_W-1:0] ld_size_ff;
   logic              ld_busy_ff;

   // candidates
   logic [NP-1:0]     cv_ff, cv_in;
   logic [SIZE_W-1:0] cl_ff [NP];
   logic [SIZE_W-1:0] cl_in [NP];
   logic [IDX_W-1:0]  ci_ff [NP];
   logic [IDX_W-1:0]  ci_in [NP];

   logic [NP-1:0]     fit_v;
   logic [SIZE_W-1:0] fit_l [NP];
   logic [SIZE_W-1:0] in_psize;

   // response register
   logic [STAT_W-1:0]  rs_ff, rs_in;
   logic [BIDX_W-1:0]  rb_ff, rb_in;
   logic [SIZE_W-1:0]  rr_ff, rr_in;
   logic [OSLOT_W-1:0] rsl_ff, rsl_in;
   logic               rrec_ff, rrec_in;

   logic                       win_v;
   logic [SIZE_W-1:0]          win_l;
   logic [IDX_W-1:0]           win_i;
   logic [SLOTS_PER_BLOCK-1:0] row, free_one;
   logic [SLOT_W-1:0]          slot_enc;
   logic [IDX_W+BIDX_W-1:0]    ld_ext, win_ext;
   logic [SLOT_W+OSLOT_W-1:0]  slot_ext;
   logic                       ld_ok;
   logic [IDX_W-1:0]           ld_pos;

   function automatic logic take_left(input logic [POL_W-1:0] pol,
                                      input logic av, input logic [SIZE_W-1:0] al,
                                      input logic bv, input logic [SIZE_W-1:0] bl);
      logic r;
      if (!av) begin
         r = 1'b0;
      end else if (!bv) begin
         r = 1'b1;
      end else begin
         case (pol)
            POL_BEST:  r = (al <= bl);
            POL_WORST: r = (al >= bl);
            default:   r = 1'b1;
         endcase
      end
      return r;
   endfunction

   assign in_psize      = req_tdata[REQ_PSIZE_LO +: SIZE_W];
   assign stat.in_alloc = (req_tuser == CMD_ALLOC);

   // per-block fit check against the incoming request
   for (genvar g = 0; g < NP; g++) begin : g_fit
      if (g < NUM_BLOCKS) begin : g_real
         assign fit_v[g] = !busy_ff[g] && (free_ff[g] >= in_psize);
         assign fit_l[g] = free_ff[g] - in_psize;
      end else begin : g_pad
         assign fit_v[g] = 1'b0;
         assign fit_l[g] = '0;
      end
   end

   // capture, then halve the candidate list once per reduce step;
   // the lower half of each pair holds the lower block indexes
   always_comb begin
      cv_in = cv_ff;
      cl_in = cl_ff;
      ci_in = ci_ff;
      if (cmd.capture) begin
         for (int i = 0; i < NP; i++) begin
            cv_in[i] = fit_v[i];
            cl_in[i] = fit_l[i];
            ci_in[i] = IDX_W'(i);
         end
      end else if (cmd.reduce) begin
         for (int i = 0; i < NP / 2; i++) begin
            if (take_left(pol_ff, cv_ff[2*i], cl_ff[2*i], cv_ff[2*i+1], cl_ff[2*i+1])) begin
               cv_in[i] = cv_ff[2*i];
               cl_in[i] = cl_ff[2*i];
               ci_in[i] = ci_ff[2*i];
            end else begin
               cv_in[i] = cv_ff[2*i+1];
               cl_in[i] = cl_ff[2*i+1];
               ci_in[i] = ci_ff[2*i+1];
            end
         end
      end
   end

   assign win_v    = cv_ff[0];
   assign win_l    = cl_ff[0];
   assign win_i    = ci_ff[0];
   assign row      = slots_ff[win_i];
   assign free_one = ~row & (row + SLOTS_PER_BLOCK'(1));   // lowest empty slot
   assign win_ext  = {BIDX_W'(0), win_i};
   assign slot_ext = {OSLOT_W'(0), slot_enc};
   assign ld_ext   = {IDX_W'(0), ld_idx_ff};
   assign ld_ok    = (ld_ext < (IDX_W+BIDX_W)'(NUM_BLOCKS));
   assign ld_pos   = ld_ext[IDX_W-1:0];

   always_comb begin
      slot_enc = '0;
      for (int s = 0; s < SLOTS_PER_BLOCK; s++) begin
         if (free_one[s]) slot_enc = slot_enc | SLOT_W'(s);
      end
   end

   always_comb begin
      free_in  = free_ff;
      busy_in  = busy_ff;
      slots_in = slots_ff;
      rs_in    = rs_ff;
      rb_in    = rb_ff;
      rr_in    = rr_ff;
      rsl_in   = rsl_ff;
      rrec_in  = rrec_ff;
      if (cmd.commit) begin
         if (cmd_ff == CMD_LOAD) begin
            rs_in   = ST_LOADED;
            rb_in   = ld_idx_ff;
            rr_in   = ld_ok ? ld_size_ff : '0;
            rsl_in  = '0;
            rrec_in = 1'b0;
            if (ld_ok) begin
               free_in[ld_pos]  = ld_size_ff;
               busy_in[ld_pos]  = ld_busy_ff;
               slots_in[ld_pos] = '0;
            end
         end else if (win_v) begin
            rs_in   = ST_ALLOCATED;
            rb_in   = win_ext[BIDX_W-1:0];
            rr_in   = win_l;
            rsl_in  = slot_ext[OSLOT_W-1:0];
            rrec_in = |free_one;
            free_in[win_i]  = win_l;
            slots_in[win_i] = row | free_one;
            if (win_l == '0) busy_in[win_i] = 1'b1;
         end else begin
            rs_in   = ST_NO_FIT;
            rb_in   = '0;
            rr_in   = '0;
            rsl_in  = '0;
            rrec_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= '1;
         pol_ff  <= POL_FIRST;
         for (int b = 0; b < NUM_BLOCKS; b++) begin
            free_ff[b]  <= '0;
            slots_ff[b] <= '0;
         end
      end else begin
         busy_ff  <= busy_in;
         free_ff  <= free_in;
         slots_ff <= slots_in;
         if (csr_we) pol_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      cv_ff   <= cv_in;
      cl_ff   <= cl_in;
      ci_ff   <= ci_in;
      rs_ff   <= rs_in;
      rb_ff   <= rb_in;
      rr_ff   <= rr_in;
      rsl_ff  <= rsl_in;
      rrec_ff <= rrec_in;
      if (cmd.capture) begin
         cmd_ff     <= req_tuser;
         ld_idx_ff  <= req_tdata[REQ_IDX_LO +: BIDX_W];
         ld_size_ff <= req_tdata[REQ_SIZE_LO +: SIZE_W];
         ld_busy_ff <= req_tdata[REQ_BUSY_BIT];
      end
   end

   assign rsp_tuser = rs_ff;
   assign rsp_tdata = {rrec_ff, rsl_ff, rr_ff, rb_ff};

endmodule

### rtl/fpba_ctrl.sv
// ----------------------------------------------------------------------------
// fpba_ctrl
// Sequencer: capture, reduction steps, commit, response valid.
// ----------------------------------------------------------------------------
module fpba_ctrl
   import fpba_pkg::*;
#(
   parameter int NUM_BLOCKS = NUM_BLOCKS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output dp_cmd_type  cmd,
   input  dp_stat_type stat
);

   localparam int IDX_W = $clog2(NUM_BLOCKS);
   localparam int LVL_W = $clog2(IDX_W + 1);

   state_type          state_ff, state_in;
   logic [LVL_W-1:0]   lvl_ff, lvl_in;
   logic               rv_ff, rv_in;

   always_comb begin
      state_in    = state_ff;
      lvl_in      = lvl_ff;
      cmd         = '0;
      req_tready  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               lvl_in      = '0;
               state_in    = stat.in_alloc ? S_REDUCE : S_COMMIT;
            end
         end
         S_REDUCE: begin
            cmd.reduce = 1'b1;
            lvl_in     = lvl_ff + LVL_W'(1);
            if (lvl_ff == LVL_W'(IDX_W - 1)) state_in = S_COMMIT;
         end
         S_COMMIT: begin
            // wait for the response register to drain
            if (!rv_ff || rsp_tready) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rv_in      = cmd.commit ? 1'b1 : (rsp_tready ? 1'b0 : rv_ff);
   assign rsp_tvalid = rv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         lvl_ff   <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         lvl_ff   <= lvl_in;
         rv_ff    <= rv_in;
      end
   end

endmodule

### rtl/fpba_checker.sv
// ----------------------------------------------------------------------------
// fpba_checker
// Port-level checks on the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module fpba_checker
   import fpba_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [STAT_W-1:0]     rsp_tuser,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic [1:0] pend_ff, pend_in;
   logic       req_hs, rsp_hs;

   assign req_hs  = req_tvalid & req_tready;
   assign rsp_hs  = rsp_tvalid & rsp_tready;
   assign pend_in = pend_ff + {1'b0, req_hs} - {1'b0, rsp_hs};

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // one response per request, no invented ones
   a_rsp_owed: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> pend_ff != 2'd0)
      else $error("response without a pending request");

   a_pend_bound: assert property (@(posedge clock) disable iff (reset)
      pend_ff != 2'd3)
      else $error("too many requests in flight");

   a_nofit_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == ST_NO_FIT || rsp_tuser == ST_UNUSED) |-> rsp_tdata == '0)
      else $error("no-fit response with nonzero fields");

   a_load_noslot: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == ST_LOADED
         |-> rsp_tdata[RSP_DATA_W-1:RSP_SLOT_LO] == '0)
      else $error("load response reports a slot");

endmodule

bind fit_policy_block_allocator fpba_checker u_fpba_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tuser  (rsp_tuser),
   .rsp_tdata  (rsp_tdata)
);

### dv/fpba_table_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpba_table_checker
// Watches the request, response and policy channels of the allocator, keeps
// its own copy of the block table, predicts each response and compares.
// ----------------------------------------------------------------------------
module fpba_table_checker
   import fpba_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic                  req_tuser,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [STAT_W-1:0]     rsp_tuser,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [POL_W-1:0]      csr_data,
   output int                    fail_count,
   output int                    outstanding,
   output int                    checked_count,
   output int                    no_fit_count,
   output int                    slots_full_count
);

   localparam int BLOCKS = NUM_BLOCKS_DEF;
   localparam int SLOTS  = SLOTS_PER_BLOCK_DEF;

   typedef struct packed {
      logic [STAT_W-1:0]  status;
      logic [BIDX_W-1:0]  blk;
      logic [SIZE_W-1:0]  remain;
      logic [OSLOT_W-1:0] slot;
      logic               rec;
   } outcome_type;

   logic [SIZE_W-1:0] free_units [BLOCKS];
   logic              occupied   [BLOCKS];
   logic [SLOTS-1:0]  slot_taken [BLOCKS];
   logic [POL_W-1:0]  policy;
   outcome_type       awaited_outcomes [$];

   initial begin
      fail_count       = 0;
      outstanding      = 0;
      checked_count    = 0;
      no_fit_count     = 0;
      slots_full_count = 0;
   end

   // Updates the table for one request and returns the response it must give.
   function automatic outcome_type apply_request(input logic cmd,
                                                 input logic [REQ_DATA_W-1:0] d);
      outcome_type       res;
      logic [BIDX_W-1:0] idx;
      logic [SIZE_W-1:0] want;
      bit                found;
      int                pick;
      int                best_left;
      int                left;
      res = '0;
      if (cmd == CMD_LOAD) begin
         idx        = d[REQ_IDX_LO +: BIDX_W];
         res.status = ST_LOADED;
         res.blk    = idx;
         if (int'(idx) < BLOCKS) begin
            free_units[idx] = d[REQ_SIZE_LO +: SIZE_W];
            occupied[idx]   = d[REQ_BUSY_BIT];
            slot_taken[idx] = '0;
            res.remain      = d[REQ_SIZE_LO +: SIZE_W];
         end
         return res;
      end
      want      = d[REQ_PSIZE_LO +: SIZE_W];
      found     = 0;
      pick      = 0;
      best_left = 0;
      for (int b = 0; b < BLOCKS; b++) begin
         if (!occupied[b] && free_units[b] >= want) begin
            left = int'(free_units[b]) - int'(want);
            if (!found) begin
               found     = 1;
               pick      = b;
               best_left = left;
               // first fit, and the spare policy code, stop at the first hit
               if (policy != POL_BEST && policy != POL_WORST) break;
            end else if (policy == POL_BEST && left < best_left) begin
               pick      = b;
               best_left = left;
            end else if (policy == POL_WORST && left > best_left) begin
               pick      = b;
               best_left = left;
            end
         end
      end
      if (!found) begin
         res.status = ST_NO_FIT;
         return res;
      end
      res.status = ST_ALLOCATED;
      res.blk    = BIDX_W'(pick);
      for (int s = 0; s < SLOTS; s++) begin
         if (!slot_taken[pick][s]) begin
            slot_taken[pick][s] = 1'b1;
            res.slot            = OSLOT_W'(s);
            res.rec             = 1'b1;
            break;
         end
      end
      free_units[pick] = free_units[pick] - want;
      res.remain       = free_units[pick];
      if (free_units[pick] == '0) occupied[pick] = 1'b1;
      return res;
   endfunction

   function automatic int field_differs(input string name, input int exp_val,
                                        input int act_val);
      if (exp_val == act_val) return 0;
      $display("%0t ns: response %s mismatch, expected %0d, actual %0d",
               $time, name, exp_val, act_val);
      return 1;
   endfunction

   always @(posedge clock) begin
      outcome_type want_res;
      outcome_type got_res;
      int          bad;
      if (reset) begin
         for (int b = 0; b < BLOCKS; b++) begin
            free_units[b] = '0;
            occupied[b]   = 1'b1;
            slot_taken[b] = '0;
         end
         policy = POL_FIRST;
         awaited_outcomes.delete();
      end else begin
         if (csr_valid && csr_ready) policy = csr_data;

         if (rsp_tvalid && rsp_tready) begin
            got_res.status = rsp_tuser;
            got_res.blk    = rsp_tdata[RSP_BLK_LO +: BIDX_W];
            got_res.remain = rsp_tdata[RSP_REM_LO +: SIZE_W];
            got_res.slot   = rsp_tdata[RSP_SLOT_LO +: OSLOT_W];
            got_res.rec    = rsp_tdata[RSP_REC_BIT];
            if (awaited_outcomes.size() == 0) begin
               $display("%0t ns: response with none expected, actual status %0d block %0d",
                        $time, got_res.status, got_res.blk);
               fail_count++;
            end else begin
               want_res = awaited_outcomes.pop_front();
               checked_count++;
               bad = 0;
               bad += field_differs("status", int'(want_res.status),
                                    int'(got_res.status));
               bad += field_differs("chosen_block", int'(want_res.blk),
                                    int'(got_res.blk));
               bad += field_differs("remaining_size", int'(want_res.remain),
                                    int'(got_res.remain));
               bad += field_differs("slot_index", int'(want_res.slot),
                                    int'(got_res.slot));
               bad += field_differs("slot_recorded", int'(want_res.rec),
                                    int'(got_res.rec));
               if (bad != 0) fail_count++;
            end
         end

         if (req_tvalid && req_tready) begin
            want_res = apply_request(req_tuser, req_tdata);
            awaited_outcomes.push_back(want_res);
            if (want_res.status == ST_NO_FIT) no_fit_count++;
            if (want_res.status == ST_ALLOCATED && !want_res.rec) slots_full_count++;
         end
      end
      outstanding = awaited_outcomes.size();
   end

endmodule

### dv/fit_policy_block_allocator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fit_policy_block_allocator_tb
// Drives load and allocate requests through the allocator under all policy
// codes, with bursty requests and a stalling response side; the table checker
// predicts and compares every response.
// ----------------------------------------------------------------------------
module fit_policy_block_allocator_tb;
   import fpba_pkg::*;

   localparam int CYCLE_LIMIT     = 300000;
   localparam int HOLD_OFF_CYCLES = 80;
   localparam int RANDOM_PHASES   = 8;
   localparam int PHASE_ITEMS     = 50;
   localparam int SETTLE_CYCLES   = 10;

   // policy code with no meaning of its own; behaves as first fit
   localparam logic [POL_W-1:0] POL_SPARE = 2'd3;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tuser  = CMD_LOAD;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tready = 1'b0;
   logic                  csr_valid  = 1'b0;
   logic [POL_W-1:0]      csr_data   = POL_FIRST;
   logic                  req_tready;
   logic                  rsp_tvalid;
   logic [STAT_W-1:0]     rsp_tuser;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_ready;

   int fail_count;
   int outstanding;
   int checked_count;
   int no_fit_count;
   int slots_full_count;
   int cycle_count      = 0;
   bit hold_off_request = 0;

   logic [POL_W-1:0] policy_order [4] = '{POL_WORST, POL_FIRST, POL_BEST, POL_SPARE};

   fit_policy_block_allocator uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   fpba_table_checker checker_i (
      .clock            (clock),
      .reset            (reset),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tuser        (req_tuser),
      .req_tdata        (req_tdata),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tuser        (rsp_tuser),
      .rsp_tdata        (rsp_tdata),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_data         (csr_data),
      .fail_count       (fail_count),
      .outstanding      (outstanding),
      .checked_count    (checked_count),
      .no_fit_count     (no_fit_count),
      .slots_full_count (slots_full_count)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycle_count, outstanding);
         $display("fit_policy_block_allocator_tb NOT OK");
         $finish;
      end
   end

   // Response side: random stall patterns, plus one long hold-off on request.
   initial begin
      int mode;
      int mode_left;
      int tick;
      mode_left = 0;
      tick      = 0;
      forever begin
         @(negedge clock);
         if (hold_off_request) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_OFF_CYCLES - 1) @(negedge clock);
            hold_off_request = 0;
         end else begin
            if (mode_left == 0) begin
               mode      = $urandom_range(0, 3);
               mode_left = $urandom_range(8, 40);
            end
            mode_left--;
            tick++;
            case (mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= 1'($urandom_range(0, 1));
               2: rsp_tready <= ($urandom_range(0, 3) == 0);
               default: rsp_tready <= (tick % 3 != 0);
            endcase
         end
      end
   end

   // tdata: index, block size, in-use mark, process id, process size, pad
   task automatic send_request(input logic cmd, input logic [BIDX_W-1:0] idx,
                               input logic [SIZE_W-1:0] bsize, input logic busy,
                               input logic [SIZE_W-1:0] pid,
                               input logic [SIZE_W-1:0] psize);
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {3'b000, psize, pid, busy, bsize, idx};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic idle_sender(input int n);
      repeat (n) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         req_tdata  <= REQ_DATA_W'({$urandom, $urandom});
      end
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_policy(input logic [POL_W-1:0] pol);
      wait_drained();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= pol;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic send_random_request();
      logic              cmd;
      logic [SIZE_W-1:0] bsize;
      logic [SIZE_W-1:0] psize;
      int                pick;
      cmd  = ($urandom_range(0, 99) < 25) ? CMD_LOAD : CMD_ALLOC;
      pick = $urandom_range(0, 9);
      if (pick < 5)       bsize = SIZE_W'($urandom_range(0, 255));
      else if (pick < 8)  bsize = SIZE_W'($urandom_range(0, 65535));
      else if (pick == 8) bsize = '0;
      else                bsize = '1;
      // mostly small requests so blocks get carved up and slots run out
      pick = $urandom_range(0, 9);
      if (pick < 4)       psize = SIZE_W'($urandom_range(0, 31));
      else if (pick < 7)  psize = SIZE_W'($urandom_range(0, 255));
      else if (pick < 9)  psize = SIZE_W'($urandom_range(0, 65535));
      else                psize = $urandom_range(0, 1) ? '1 : '0;
      send_request(cmd, BIDX_W'($urandom_range(0, 15)), bsize,
                   ($urandom_range(0, 4) == 0), SIZE_W'($urandom_range(0, 65535)),
                   psize);
   endtask

   task automatic run_random(input int n, input bit back_to_back);
      int burst_left;
      burst_left = $urandom_range(1, 12);
      for (int i = 0; i < n; i++) begin
         send_random_request();
         burst_left--;
         if (burst_left == 0) begin
            if (!back_to_back) idle_sender($urandom_range(1, 10));
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 12);
         end
      end
   endtask

   initial begin
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      // every block comes up in use, so even a zero request has no fit
      send_request(CMD_ALLOC, 4'd0, 16'd0, 1'b0, 16'hFFFF, 16'd0);
      send_request(CMD_LOAD, 4'd0, 16'd0, 1'b0, 16'd0, 16'd0);
      send_request(CMD_LOAD, 4'd15, 16'hFFFF, 1'b0, 16'd0, 16'd0);
      send_request(CMD_LOAD, 4'd5, 16'd100, 1'b1, 16'd0, 16'd0);
      send_request(CMD_LOAD, 4'd3, 16'd40, 1'b0, 16'd0, 16'd0);
      send_request(CMD_LOAD, 4'd7, 16'd100, 1'b0, 16'd0, 16'd0);
      send_request(CMD_LOAD, 4'd9, 16'd60, 1'b0, 16'd0, 16'd0);
      // zero request lands on the empty block 0 and marks it used
      send_request(CMD_ALLOC, 4'd0, 16'd0, 1'b0, 16'd0, 16'd0);
      send_request(CMD_ALLOC, 4'd0, 16'd0, 1'b0, 16'd1, 16'hFFFF);
      send_request(CMD_ALLOC, 4'd0, 16'd0, 1'b0, 16'd2, 16'hFFFF);
      // nine requests into block 3: the last finds its slots full
      for (int i = 0; i < 9; i++)
         send_request(CMD_ALLOC, 4'd0, 16'd0, 1'b0, 16'(100 + i), 16'd1);
      write_policy(POL_BEST);
      send_request(CMD_ALLOC, 4'd0, 16'd0, 1'b0, 16'h1234, 16'd50);
      write_policy(POL_WORST);
      send_request(CMD_ALLOC, 4'd0, 16'd0, 1'b0, 16'h4321, 16'd5);
      write_policy(POL_SPARE);
      send_request(CMD_ALLOC, 4'd0, 16'd0, 1'b0, 16'h0F0F, 16'd1);
      // equal free space on blocks 3 and 7, but block 9 fits exactly and wins
      send_request(CMD_LOAD, 4'd7, 16'd30, 1'b0, 16'd0, 16'd0);
      write_policy(POL_BEST);
      send_request(CMD_ALLOC, 4'd0, 16'd0, 1'b0, 16'hF0F0, 16'd10);

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         write_policy((p < 4) ? policy_order[p] : POL_W'($urandom_range(0, 3)));
         if (p == 1) begin
            // responses held back while requests keep coming: input must stall
            hold_off_request = 1;
            run_random(30, 1'b1);
            run_random(PHASE_ITEMS - 30, 1'b0);
         end else if (p == 3) begin
            run_random(PHASE_ITEMS / 2, 1'b0);
            wait_drained();
            run_random(PHASE_ITEMS / 2, 1'b0);
         end else begin
            run_random(PHASE_ITEMS, 1'b0);
         end
      end

      wait_drained();
      $display("covered: %0d responses checked over all four policy codes",
               checked_count);
      $display("covered: %0d no-fit responses, %0d allocations with slots full",
               no_fit_count, slots_full_count);
      if (fail_count == 0) begin
         $display("fit_policy_block_allocator_tb OK");
      end else begin
         $display("fit_policy_block_allocator_tb NOT OK");
      end
      $finish;
   end

endmodule
